// File: sv/tkst_pkg.sv
// Package for the top-k score table: item types, entry layout, sequencer states.
// No dependencies; top_k_score_table.sv and tkst_seq.sv refer to it by scoped names.
`timescale 1ns / 1ps

package tkst_pkg;

    localparam int TABLE_DEPTH_DEF = 10;
    localparam int SCORE_W         = 16;
    localparam int TAG_W           = 8;
    localparam int RANK_W          = 4;
    localparam int COUNT_OUT_W     = 4;
    localparam int ENTRY_W         = SCORE_W + TAG_W;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [SCORE_W-1:0] new_score;
        logic [TAG_W-1:0]   player_tag;
        logic [RANK_W-1:0]  read_rank;
    } in_item_t;

    typedef struct packed {
        logic                   accepted;
        logic                   entry_valid;
        logic [SCORE_W-1:0]     score_out;
        logic [TAG_W-1:0]       tag_out;
        logic [COUNT_OUT_W-1:0] entry_count;
    } out_item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FULL_CHK,
        S_SCAN,
        S_PUT,
        S_RD_DATA,
        S_DONE
    } seq_state_t;

endpackage

// File: sv/top_k_score_table.sv
// Top-k score table. A read passes through S_RD_DATA, S_DONE and the output register
// to m_valid; a read whose rank lies past the entry count skips S_RD_DATA. On an insert,
// the sequencer compares and shifts one entry per cycle through the table RAM
// (one write port, one registered read port), from the bottom upward. One item is in
// work at a time; the output register lets the next item start while a result waits.
// Reset empties the table.
`timescale 1ns / 1ps

module top_k_score_table #(
    parameter int TABLE_DEPTH = tkst_pkg::TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tkst_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tkst_pkg::out_item_t m_data
);

    logic                res_valid;
    logic                res_ready;
    tkst_pkg::out_item_t res_item;

    logic                out_valid_reg, out_valid_next;
    tkst_pkg::out_item_t out_data_reg, out_data_next;

    tkst_seq #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (s_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_item (res_item)
    );

    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
            if (res_valid) begin
                out_data_next = res_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: sv/tkst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module tkst_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 10,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/tkst_seq.sv
// Sequencer of the top-k score table: walks the table upward from the bottom,
// one compare and one shifted entry per cycle, through tkst_ram. Uses tkst_pkg.
`timescale 1ns / 1ps

module tkst_seq #(
    parameter int TABLE_DEPTH = tkst_pkg::TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tkst_pkg::in_item_t  in_item,
    output logic                res_valid,
    input  logic                res_ready,
    output tkst_pkg::out_item_t res_item
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (tkst_pkg::RANK_W > CNT_W) ? tkst_pkg::RANK_W : CNT_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    tkst_pkg::seq_state_t state_reg, state_next;
    tkst_pkg::in_item_t   item_reg, item_next;
    tkst_pkg::out_item_t  res_reg, res_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    pos_reg, pos_next;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    tkst_pkg::entry_t     wr_data;
    logic [ADDR_W-1:0]    rd_addr;
    tkst_pkg::entry_t     rd_data;

    logic                 full;
    logic                 rank_ok;
    tkst_pkg::entry_t     new_entry;
    logic [CNT_W-1:0]     count_after_ins;

    tkst_ram #(
        .WIDTH (tkst_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign full            = (count_reg == CNT_W'(TABLE_DEPTH));
    assign rank_ok         = (CMP_W'(in_item.read_rank) < CMP_W'(count_reg));
    assign new_entry.score = item_reg.new_score;
    assign new_entry.tag   = item_reg.player_tag;
    assign count_after_ins = full ? count_reg : count_reg + 1'b1;

    // No item is taken while reset is held.
    assign in_ready  = aresetn && (state_reg == tkst_pkg::S_IDLE);
    assign res_valid = (state_reg == tkst_pkg::S_DONE);
    assign res_item  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tkst_pkg::S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        item_reg <= item_next;
        res_reg  <= res_next;
        pos_reg  <= pos_next;
    end

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = new_entry;
        rd_addr    = pos_reg - 1'b1;

        case (state_reg)
            tkst_pkg::S_IDLE: begin
                if (in_valid) begin
                    item_next = in_item;
                    res_next  = '0;
                    res_next.entry_count = tkst_pkg::COUNT_OUT_W'(count_reg);
                    if (in_item.req_type == tkst_pkg::REQ_READ) begin
                        rd_addr = ADDR_W'(in_item.read_rank);
                        if (rank_ok) begin
                            state_next = tkst_pkg::S_RD_DATA;
                        end else begin
                            state_next = tkst_pkg::S_DONE;
                        end
                    end else if (full) begin
                        // The bottom entry decides whether the item gets in at all.
                        rd_addr    = LAST_ADDR;
                        state_next = tkst_pkg::S_FULL_CHK;
                    end else begin
                        pos_next   = ADDR_W'(count_reg);
                        rd_addr    = ADDR_W'(count_reg) - 1'b1;
                        state_next = (count_reg == '0) ? tkst_pkg::S_PUT : tkst_pkg::S_SCAN;
                    end
                end
            end

            tkst_pkg::S_FULL_CHK: begin
                if (rd_data.score < item_reg.new_score) begin
                    // The bottom entry is dropped; shifting starts one rank above it.
                    pos_next   = LAST_ADDR;
                    rd_addr    = LAST_ADDR - 1'b1;
                    state_next = (LAST_ADDR == '0) ? tkst_pkg::S_PUT : tkst_pkg::S_SCAN;
                end else begin
                    state_next = tkst_pkg::S_DONE;
                end
            end

            tkst_pkg::S_SCAN: begin
                wr_en = 1'b1;
                if (rd_data.score >= item_reg.new_score) begin
                    // Equal scores stay above, so ties keep their arrival order.
                    count_next           = count_after_ins;
                    res_next.accepted    = 1'b1;
                    res_next.entry_count = tkst_pkg::COUNT_OUT_W'(count_after_ins);
                    state_next           = tkst_pkg::S_DONE;
                end else begin
                    wr_data  = rd_data;
                    pos_next = pos_reg - 1'b1;
                    rd_addr  = pos_reg - 2'd2;
                    if (pos_reg == ADDR_W'(1)) begin
                        state_next = tkst_pkg::S_PUT;
                    end
                end
            end

            tkst_pkg::S_PUT: begin
                wr_en                = 1'b1;
                count_next           = count_after_ins;
                res_next.accepted    = 1'b1;
                res_next.entry_count = tkst_pkg::COUNT_OUT_W'(count_after_ins);
                state_next           = tkst_pkg::S_DONE;
            end

            tkst_pkg::S_RD_DATA: begin
                res_next.entry_valid = 1'b1;
                res_next.score_out   = rd_data.score;
                res_next.tag_out     = rd_data.tag;
                state_next           = tkst_pkg::S_DONE;
            end

            tkst_pkg::S_DONE: begin
                if (res_ready) begin
                    state_next = tkst_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = tkst_pkg::S_IDLE;
            end
        endcase
    end

endmodule
